@@ design/glfj_pkg.sv @@
// ----------------------------------------------------------------------------
// glfj_pkg
// Shared constants for the greedy line fill and justify core: register
// indexes, alignment codes and whitespace decoding.
// ----------------------------------------------------------------------------
package glfj_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 32;
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned CFG_DATA_W    = 6;
  localparam int unsigned CHAR_W        = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALIGN_MODE = 1'b1;

  localparam logic [1:0] ALIGN_LEFT    = 2'd0;
  localparam logic [1:0] ALIGN_JUSTIFY = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT   = 2'd2;
  localparam logic [1:0] ALIGN_CENTER  = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_VT    = 8'd11;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

@@ design/greedy_line_fill_justify_core.sv @@
// ----------------------------------------------------------------------------
// greedy_line_fill_justify_core
// Greedy word wrap with left, justified, right and centered line output.
// Word bytes are stored as they arrive. A separator copies the held word from
// the word memory into the line: a space, then a read and a write per letter
// (registered reads). An emitted line runs start, gap division in justified
// mode, leading pad, letters with gaps widened, trailing pad. Memories keep
// data; reset sets config defaults, clears state, word/line counts, tvalid.
// ----------------------------------------------------------------------------
module greedy_line_fill_justify_core
  import glfj_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = glfj_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // char_code[7:0]
  input  logic [glfj_pkg::CHAR_W-1:0]      s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // out_char[7:0]
  output logic [glfj_pkg::CHAR_W-1:0]      m_axis_tdata_o,
  // line_end[0]
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             cfg_we_i,
  input  logic [glfj_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [glfj_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_PLACE    = 11'b00000000010,
    ST_CP_RD    = 11'b00000000100,
    ST_CP_WR    = 11'b00000001000,
    ST_EM_START = 11'b00000010000,
    ST_EM_DIV   = 11'b00000100000,
    ST_EM_LEAD  = 11'b00001000000,
    ST_EM_RD    = 11'b00010000000,
    ST_EM_CH    = 11'b00100000000,
    ST_EM_GAP   = 11'b01000000000,
    ST_EM_TRAIL = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] line_width_q;
  logic [1:0]            align_q;

  logic [CW-1:0] word_len_q, word_len_d;
  logic [CW-1:0] letters_q, letters_d;
  logic [5:0]    words_q, words_d;
  logic [CW-1:0] wl_q, wl_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] gi_q, gi_d;
  logic [CW-1:0] spc_q, spc_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] lead_q, lead_d;
  logic [CW-1:0] trail_q, trail_d;
  logic [CW-1:0] base_q, base_d;
  logic [CW-1:0] extra_q, extra_d;
  logic          expand_q, expand_d;
  logic          final_q, final_d;
  logic          ret_place_q, ret_place_d;
  logic          eot_q, eot_d;

  logic              oval_q;
  logic [CHAR_W-1:0] ochar_q;
  logic              oend_q, olast_q;

  logic [CHAR_W-1:0] line_mem [MAX_WIDTH];
  logic [CHAR_W-1:0] word_mem [MAX_WIDTH];
  logic [CHAR_W-1:0] lm_rdata_q, wm_rdata_q;
  logic              lm_we, lm_re, wm_we, wm_re;
  logic [AW-1:0]     lm_waddr, lm_raddr, wm_waddr, wm_raddr;
  logic [CHAR_W-1:0] lm_wdata, wm_wdata;

  logic              div_start, div_done;
  logic [CW-1:0]     div_dividend, div_divisor, div_quot, div_rem;

  logic [CW-1:0]     w_eff, wl_cur, gaps, pad, e_sp;
  logic [CW:0]       need;
  logic              in_fire, slot_free, emit_req, emit_fire, emit_end;
  logic [CHAR_W-1:0] emit_char;

  always_comb begin
    if (line_width_q == '0) begin
      w_eff = CW'(1);
    end else if (line_width_q > CFG_DATA_W'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(line_width_q);
    end
  end

  assign wl_cur = (word_len_q > w_eff) ? w_eff : word_len_q;
  assign need   = {1'b0, letters_q} + (CW+1)'(1) + {1'b0, wl_cur};
  assign gaps   = CW'(words_q - 6'd1);
  assign pad    = w_eff - (letters_q - gaps);
  assign e_sp   = w_eff - letters_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !oval_q || m_axis_tready_i;
  assign emit_fire       = emit_req && slot_free;
  assign emit_end        = (ocnt_q == total_q - CW'(1));

  assign div_dividend = pad;
  assign div_divisor  = gaps;

  glfj_div #(
    .W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    word_len_d  = word_len_q;
    letters_d   = letters_q;
    words_d     = words_q;
    wl_d        = wl_q;
    idx_d       = idx_q;
    gi_d        = gi_q;
    spc_d       = spc_q;
    ocnt_d      = ocnt_q;
    total_d     = total_q;
    lead_d      = lead_q;
    trail_d     = trail_q;
    base_d      = base_q;
    extra_d     = extra_q;
    expand_d    = expand_q;
    final_d     = final_q;
    ret_place_d = ret_place_q;
    eot_d       = eot_q;
    lm_we       = 1'b0;
    lm_waddr    = letters_q[AW-1:0];
    lm_wdata    = CHAR_SPACE;
    lm_re       = 1'b0;
    lm_raddr    = idx_q[AW-1:0];
    wm_we       = 1'b0;
    wm_waddr    = word_len_q[AW-1:0];
    wm_wdata    = s_axis_tdata_i;
    wm_re       = 1'b0;
    wm_raddr    = idx_q[AW-1:0];
    div_start   = 1'b0;
    emit_req    = 1'b0;
    emit_char   = CHAR_SPACE;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!s_axis_tlast_i && !is_sep(s_axis_tdata_i)) begin
            if (word_len_q < w_eff && word_len_q < CW'(MAX_WIDTH)) begin
              wm_we      = 1'b1;
              word_len_d = word_len_q + CW'(1);
            end
          end else begin
            eot_d = s_axis_tlast_i;
            wl_d  = wl_cur;
            if (wl_cur == '0) begin
              if (s_axis_tlast_i) begin
                final_d     = 1'b1;
                ret_place_d = 1'b0;
                state_d     = ST_EM_START;
              end
            end else if (words_q != '0 && need > {1'b0, w_eff}) begin
              final_d     = !s_axis_tlast_i;
              ret_place_d = 1'b1;
              state_d     = ST_EM_START;
            end else begin
              state_d = ST_PLACE;
            end
          end
        end
      end
      ST_PLACE: begin
        if (words_q != '0 && letters_q < CW'(MAX_WIDTH)) begin
          lm_we     = 1'b1;
          letters_d = letters_q + CW'(1);
        end
        idx_d   = '0;
        state_d = ST_CP_RD;
      end
      ST_CP_RD: begin
        if (idx_q < wl_q && letters_q < CW'(MAX_WIDTH)) begin
          wm_re   = 1'b1;
          state_d = ST_CP_WR;
        end else begin
          words_d    = words_q + 6'd1;
          word_len_d = '0;
          if (eot_q) begin
            final_d     = 1'b1;
            ret_place_d = 1'b0;
            state_d     = ST_EM_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CP_WR: begin
        lm_we     = 1'b1;
        lm_wdata  = wm_rdata_q;
        letters_d = letters_q + CW'(1);
        idx_d     = idx_q + CW'(1);
        state_d   = ST_CP_RD;
      end
      ST_EM_START: begin
        ocnt_d   = '0;
        idx_d    = '0;
        gi_d     = '0;
        lead_d   = '0;
        trail_d  = '0;
        expand_d = 1'b0;
        total_d  = w_eff;
        if (words_q == '0 || letters_q == '0) begin
          state_d = ret_place_q ? ST_PLACE : ST_IDLE;
        end else if (align_q == ALIGN_LEFT || letters_q >= w_eff) begin
          total_d = letters_q;
          state_d = ST_EM_LEAD;
        end else begin
          state_d = ST_EM_LEAD;
          unique case (align_q)
            ALIGN_JUSTIFY: begin
              if (gaps == '0) begin
                trail_d = pad;
              end else begin
                expand_d  = 1'b1;
                div_start = 1'b1;
                state_d   = ST_EM_DIV;
              end
            end
            ALIGN_RIGHT: lead_d = e_sp;
            ALIGN_CENTER: begin
              lead_d  = e_sp - (e_sp >> 1);
              trail_d = e_sp >> 1;
            end
            default: lead_d = '0;
          endcase
        end
      end
      ST_EM_DIV: begin
        if (div_done) begin
          base_d  = div_quot;
          extra_d = div_rem;
          state_d = ST_EM_LEAD;
        end
      end
      ST_EM_LEAD: begin
        if (lead_q == '0) begin
          state_d = ST_EM_RD;
        end else begin
          emit_req = 1'b1;
          if (emit_fire) begin
            lead_d = lead_q - CW'(1);
          end
        end
      end
      ST_EM_RD: begin
        if (idx_q < letters_q) begin
          lm_re   = 1'b1;
          state_d = ST_EM_CH;
        end else begin
          state_d = ST_EM_TRAIL;
        end
      end
      ST_EM_CH: begin
        if (expand_q && lm_rdata_q == CHAR_SPACE) begin
          spc_d   = base_q + ((gi_q < extra_q) ? CW'(1) : CW'(0));
          gi_d    = gi_q + CW'(1);
          state_d = ST_EM_GAP;
        end else begin
          emit_req  = 1'b1;
          emit_char = lm_rdata_q;
          if (emit_fire) begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      ST_EM_GAP: begin
        emit_req = 1'b1;
        if (emit_fire) begin
          spc_d = spc_q - CW'(1);
          if (spc_q == CW'(1)) begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      ST_EM_TRAIL: begin
        if (trail_q == '0) begin
          letters_d = '0;
          words_d   = '0;
          state_d   = ret_place_q ? ST_PLACE : ST_IDLE;
        end else begin
          emit_req = 1'b1;
          if (emit_fire) begin
            trail_d = trail_q - CW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit_fire) begin
      ocnt_d = ocnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      line_mem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      lm_rdata_q <= line_mem[lm_raddr];
    end
    if (wm_we) begin
      word_mem[wm_waddr] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rdata_q <= word_mem[wm_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      line_width_q <= CFG_DATA_W'(32);
      align_q      <= ALIGN_LEFT;
      word_len_q   <= '0;
      letters_q    <= '0;
      words_q      <= '0;
      oval_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_len_q <= word_len_d;
      letters_q  <= letters_d;
      words_q    <= words_d;
      if (slot_free) begin
        oval_q <= emit_fire;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_LINE_WIDTH: line_width_q <= cfg_wdata_i;
          CFG_ALIGN_MODE: align_q      <= cfg_wdata_i[1:0];
          default:        align_q      <= align_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wl_q        <= wl_d;
    idx_q       <= idx_d;
    gi_q        <= gi_d;
    spc_q       <= spc_d;
    ocnt_q      <= ocnt_d;
    total_q     <= total_d;
    lead_q      <= lead_d;
    trail_q     <= trail_d;
    base_q      <= base_d;
    extra_q     <= extra_d;
    expand_q    <= expand_d;
    final_q     <= final_d;
    ret_place_q <= ret_place_d;
    eot_q       <= eot_d;
    if (emit_fire) begin
      ochar_q <= emit_char;
      oend_q  <= emit_end;
      olast_q <= emit_end && final_q;
    end
  end

  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = ochar_q;
  assign m_axis_tuser_o  = oend_q;
  assign m_axis_tlast_o  = olast_q;

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o)
    else $error("last transfer does not close a line");

  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CP_WR) |-> (letters_q < CW'(MAX_WIDTH)))
    else $error("line memory write beyond capacity");

  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM_TRAIL && trail_q == '0) |=> (letters_q == '0 && words_q == '0))
    else $error("held line not cleared after emission");

endmodule

@@ design/glfj_div.sv @@
// ----------------------------------------------------------------------------
// glfj_div
// Small iterative divider: one subtraction per cycle, gives quotient and
// remainder of the justification padding over the gap count.
// ----------------------------------------------------------------------------
module glfj_div #(
  parameter int unsigned W = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  logic         busy_q, busy_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] div_q, div_d;
  logic         ge;

  assign ge     = (rem_q >= div_q);
  assign done_o = busy_q && !ge;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = dividend_i;
      quo_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - div_q;
        quo_d = quo_q + W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

endmodule

@@ sim/glfj_checker.sv @@
// ----------------------------------------------------------------------------
// glfj_checker
// Watches the character input, the line output and the register port of the
// greedy line fill and justify core, predicts each formatted character and
// compares it field by field with what the core emits.
// ----------------------------------------------------------------------------
module glfj_checker
  import glfj_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = glfj_pkg::MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CHAR_W-1:0]     s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [CHAR_W-1:0]     m_tdata_i,
  input  logic                  m_tuser_i,
  input  logic                  m_tlast_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    lines_seen_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              line_end;
    logic              last;
  } fmt_char_t;

  fmt_char_t         expected_chars[$];
  logic [CHAR_W-1:0] held_line[MAX_WIDTH];
  logic [CHAR_W-1:0] pending_word[MAX_WIDTH];
  int unsigned       held_len, held_words, word_len;
  logic [5:0]        width_reg;
  logic [1:0]        mode_reg;

  assign pending_o = expected_chars.size();

  function automatic int unsigned width_now();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic logic is_blank(logic [CHAR_W-1:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
           c == CHAR_CR || c == CHAR_VT || c == CHAR_FF;
  endfunction

  task automatic push_char(ref fmt_char_t q[$], input logic [CHAR_W-1:0] c);
    fmt_char_t f;
    f.ch = c;
    f.line_end = 1'b0;
    f.last = 1'b0;
    q = {q, f};
  endtask

  task automatic push_pad(ref fmt_char_t q[$], input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_char(q, CHAR_SPACE);
  endtask

  task automatic flush_line(ref fmt_char_t q[$]);
    int unsigned w, len, gaps, pad, base, extra, gi, e;
    int unsigned start;
    w = width_now();
    len = held_len;
    start = q.size();
    if (held_words == 0 || len == 0) return;
    if (len > MAX_WIDTH) len = MAX_WIDTH;
    if (mode_reg == ALIGN_LEFT || len >= w) begin
      for (int unsigned i = 0; i < len; i++) push_char(q, held_line[i]);
    end else if (mode_reg == ALIGN_JUSTIFY) begin
      gaps = held_words - 1;
      pad = w - (len - gaps);
      if (gaps == 0) begin
        for (int unsigned i = 0; i < len; i++) push_char(q, held_line[i]);
        push_pad(q, pad);
      end else begin
        base = pad / gaps;
        extra = pad % gaps;
        gi = 0;
        for (int unsigned i = 0; i < len; i++) begin
          if (held_line[i] == CHAR_SPACE) begin
            push_pad(q, base + ((gi < extra) ? 1 : 0));
            gi++;
          end else begin
            push_char(q, held_line[i]);
          end
        end
      end
    end else if (mode_reg == ALIGN_RIGHT) begin
      push_pad(q, w - len);
      for (int unsigned i = 0; i < len; i++) push_char(q, held_line[i]);
    end else begin
      e = w - len;
      push_pad(q, e - e / 2);
      for (int unsigned i = 0; i < len; i++) push_char(q, held_line[i]);
      push_pad(q, e / 2);
    end
    if (q.size() > start) q[q.size() - 1].line_end = 1'b1;
    held_len = 0;
    held_words = 0;
  endtask

  task automatic place_pending(ref fmt_char_t q[$]);
    int unsigned w, wl;
    w = width_now();
    wl = word_len;
    if (wl == 0) return;
    if (wl > w) wl = w;
    if (held_words > 0 && held_len + 1 + wl > w) flush_line(q);
    if (held_words > 0 && held_len < MAX_WIDTH) begin
      held_line[held_len] = CHAR_SPACE;
      held_len++;
    end
    for (int unsigned i = 0; i < wl && held_len < MAX_WIDTH; i++) begin
      held_line[held_len] = pending_word[i];
      held_len++;
    end
    held_words = (held_words + 1) & 63;
    word_len = 0;
  endtask

  task automatic format_char(input logic [CHAR_W-1:0] c, input logic eot);
    fmt_char_t q[$];
    if (eot) begin
      place_pending(q);
      flush_line(q);
      word_len = 0;
    end else if (is_blank(c)) begin
      place_pending(q);
    end else if (word_len < width_now() && word_len < MAX_WIDTH) begin
      pending_word[word_len] = c;
      word_len++;
    end
    if (q.size() > 0) q[q.size() - 1].last = 1'b1;
    expected_chars = {expected_chars, q};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fmt_char_t exp_c;
    if (!rst_ni) begin
      expected_chars.delete();
      held_len = 0;
      held_words = 0;
      word_len = 0;
      width_reg = 6'd32;
      mode_reg = ALIGN_LEFT;
      fail_count_o = 0;
      lines_seen_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output transfer: char %0d", m_tdata_i);
          fail_count_o++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (m_tdata_i !== exp_c.ch) begin
            $error("out_char: expected %0d, got %0d", exp_c.ch, m_tdata_i);
            fail_count_o++;
          end
          if (m_tuser_i !== exp_c.line_end) begin
            $error("line_end: expected %0d, got %0d", exp_c.line_end, m_tuser_i);
            fail_count_o++;
          end
          if (m_tlast_i !== exp_c.last) begin
            $error("last: expected %0d, got %0d", exp_c.last, m_tlast_i);
            fail_count_o++;
          end
          if (exp_c.line_end) lines_seen_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) format_char(s_tdata_i, s_tlast_i);
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_LINE_WIDTH) width_reg = cfg_wdata_i;
        else if (cfg_addr_i == CFG_ALIGN_MODE) mode_reg = cfg_wdata_i[1:0];
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Feeds text through the greedy line fill and justify core under several
// widths and all four alignments, with random stalls on both streams and one
// long output hold-off; a checker beside the core compares every character.
// ----------------------------------------------------------------------------
module tb_top;
  import glfj_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [CHAR_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CHAR_W-1:0]     m_tdata;
  logic                  m_tuser, m_tlast, m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count, pending, lines_seen;
  int                    idle_cycles = 0;
  int                    chars_sent = 0;
  bit                    calm = 1'b0;
  bit                    hold_off = 1'b0;

  always #6 clk_i = ~clk_i;

  greedy_line_fill_justify_core dut (
    .clk_i, .rst_ni,
    .s_axis_tdata_i(s_tdata), .s_axis_tlast_i(s_tlast),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .m_axis_tlast_o(m_tlast), .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  glfj_checker u_checker (
    .clk_i, .rst_ni,
    .s_tdata_i(s_tdata), .s_tlast_i(s_tlast), .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .m_tdata_i(m_tdata), .m_tuser_i(m_tuser), .m_tlast_i(m_tlast),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .lines_seen_o(lines_seen)
  );

  // Output side: random stalls, calm stretch, and the long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(input logic [CHAR_W-1:0] c, input logic eot);
    while (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata <= c;
    s_tlast <= eot;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send(txt[i], 1'b0);
  endtask

  task automatic end_text();
    send(8'h00, 1'b1);
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [5:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3 * MAX_WIDTH_DEF * 2 + 10) @(posedge clk_i);
  endtask

  task automatic configure(input logic [5:0] w, input logic [1:0] m);
    settle();
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_ALIGN_MODE, {4'd0, m});
  endtask

  function automatic logic [CHAR_W-1:0] word_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] sep_char();
    case ($urandom_range(5))
      0: return CHAR_TAB;
      1: return CHAR_LF;
      2: return CHAR_VT;
      3: return CHAR_FF;
      4: return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  task automatic random_text(input int n_items, input int max_word);
    int k;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(9) == 0) begin
        send(CHAR_W'($urandom_range(255)), 1'b0);
        k++;
      end else begin
        for (int i = $urandom_range(max_word, 1); i > 0; i--) begin
          send(word_char(), 1'b0);
          k++;
        end
        send(sep_char(), 1'b0);
        k++;
      end
    end
    end_text();
  endtask

  initial begin
    int w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, empty text, repeated separators, full fill.
    end_text();
    send_text("ab  \t\n\r");
    send(CHAR_VT, 1'b0);
    send(CHAR_FF, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    end_text();
    configure(6'd5, ALIGN_JUSTIFY);
    send_text("abcde fg hi abcdefgh x");
    end_text();
    configure(6'd5, ALIGN_RIGHT);
    send_text("abcde x ");
    end_text();
    configure(6'd5, ALIGN_CENTER);
    send_text("abcde ab ");
    end_text();
    configure(6'd0, ALIGN_CENTER);
    send_text("ab c ");
    end_text();
    configure(6'd63, ALIGN_JUSTIFY);
    send_text("word ");
    end_text();
    // Width lowered below a held line.
    configure(6'd20, ALIGN_RIGHT);
    send_text("abcdef ghijk ");
    configure(6'd4, ALIGN_RIGHT);
    end_text();

    // Long output hold-off while text keeps coming.
    configure(6'd8, ALIGN_JUSTIFY);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_text(60, 6);
    join

    calm = 1'b1;
    configure(6'd12, ALIGN_LEFT);
    random_text(60, 9);
    calm = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      w = (ph == 0) ? 1 : (ph == 1) ? 32 : $urandom_range(32, 1);
      configure(w[5:0], ph[1:0]);
      random_text(28, (w < 10) ? w + 2 : 10);
    end

    settle();
    $display("summary: %0d characters sent, %0d lines checked", chars_sent, lines_seen);
    $display("covered widths 0..63 with all four alignments and output back-pressure");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
